### src/osdq_pkg.sv
package osdq_pkg;

	// Fixed field widths of the item and result words.
	localparam int SIZE_W = 23;
	localparam int ANG_W  = 16;
	localparam int CNT_W  = 4;
	localparam int DIST_W = 26;
	localparam int NORM_W = 16;

	// Widths of the length path. Components are limited to 2^30 before squaring.
	localparam int MAG_W = 31;
	localparam int SQ_W  = 62;
	localparam int LEN_W = 31;
	localparam int QUO_W = 15;
	localparam int NUM_W = 46;

	localparam longint COMP_LIM = 64'sd1073741824;

	localparam logic signed [NORM_W-1:0] NORM_ONE = 16'sd16384;
	localparam logic signed [DIST_W-1:0] DIST_MAX = 26'sd33554431;
	localparam logic signed [DIST_W-1:0] DIST_MIN = -26'sd33554431 - 26'sd1;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;
	localparam logic KIND_CIRCLE = 1'b0;
	localparam logic KIND_BOX    = 1'b1;

endpackage

### src/osdq_if.sv
interface osdq_req_if import osdq_pkg::*; #(parameter int COORD_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic                         func;
	logic [2:0]                   slot;
	logic                         kind;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic [SIZE_W-1:0]            radius;
	logic [SIZE_W-1:0]            half_x;
	logic [SIZE_W-1:0]            half_y;
	logic signed [ANG_W-1:0]      cos_angle;
	logic signed [ANG_W-1:0]      sin_angle;

	modport source (output valid, func, slot, kind, coord_x, coord_y, radius, half_x, half_y,
		cos_angle, sin_angle, input ready);
	modport sink (input valid, func, slot, kind, coord_x, coord_y, radius, half_x, half_y,
		cos_angle, sin_angle, output ready);
endinterface

interface osdq_rsp_if import osdq_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DIST_W-1:0] distance;
	logic signed [NORM_W-1:0] normal_x;
	logic signed [NORM_W-1:0] normal_y;
	logic                     has_obstacle;

	modport source (output valid, distance, normal_x, normal_y, has_obstacle, input ready);
	modport sink (input valid, distance, normal_x, normal_y, has_obstacle, output ready);
endinterface

interface osdq_cfg_if import osdq_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/osdq_table.sv
module osdq_table #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// The read word holds between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/osdq_isqrt.sv
module osdq_isqrt import osdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_W-1:0]  radicand,
	output logic             done,
	output logic [LEN_W-1:0] root
);

	localparam int REM_W = LEN_W + 1;
	localparam int CNT_BITS = $clog2(LEN_W + 1);

	logic [SQ_W-1:0]     src_q;
	logic [REM_W-1:0]    rem_q;
	logic [LEN_W-1:0]    root_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [REM_W+1:0]    rem_sh;
	logic [REM_W+1:0]    trial;
	logic [REM_W+1:0]    diff;

	// One result bit per cycle: bring down two radicand bits, try root*4+1.
	assign rem_sh = {rem_q, src_q[SQ_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			src_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CNT_BITS'(LEN_W);
		end else if (busy_q) begin
			src_q <= src_q << 2;
			cnt_q <= cnt_q - CNT_BITS'(1);
			if (rem_sh >= trial) begin
				rem_q  <= diff[REM_W-1:0];
				root_q <= {root_q[LEN_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_W-1:0];
				root_q <= {root_q[LEN_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### src/osdq_div.sv
module osdq_div import osdq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] mag,
	input  logic [LEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quot
);

	localparam int CNT_BITS = $clog2(QUO_W + 1);

	logic [NUM_W-1:0]    num;
	logic [LEN_W-1:0]    rem_q;
	logic [QUO_W-1:0]    low_q;
	logic [QUO_W-1:0]    quot_q;
	logic [LEN_W-1:0]    den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [LEN_W:0]      r2;
	logic [LEN_W:0]      r2_sub;

	// Rounded quotient: (mag * 2^14 + den / 2) / den. As mag never exceeds den,
	// the quotient fits in QUO_W bits and the upper numerator part is below den.
	assign num    = NUM_W'({mag, 14'b0}) + NUM_W'(den >> 1);
	assign r2     = {rem_q, low_q[QUO_W-1]};
	assign r2_sub = r2 - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[NUM_W-1:QUO_W];
			low_q  <= num[QUO_W-1:0];
			den_q  <= den;
			quot_q <= '0;
			cnt_q  <= CNT_BITS'(QUO_W);
		end else if (busy_q) begin
			low_q <= low_q << 1;
			cnt_q <= cnt_q - CNT_BITS'(1);
			if (r2 >= {1'b0, den_q}) begin
				rem_q  <= r2_sub[LEN_W-1:0];
				quot_q <= {quot_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q  <= r2[LEN_W-1:0];
				quot_q <= {quot_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### src/obstacle_signed_distance_query.sv
// Obstacle signed-distance query. A table of up to MAX_OBSTACLES circles and
// rotated boxes sits in a small synchronous memory. A load word (func 0) writes
// one entry in the table and gives no result. A query word (func 1) walks
// entries 0 to obstacle_count-1, one memory read each, and returns one result
// word with the least signed distance (negative inside, Q13.12, saturated) and
// the outward unit normal of that obstacle in Q1.14; on a tie the lower slot
// wins. With no obstacles the distance reads as its maximum, the normal as
// (0, 1.0) and has_obstacle as zero. A circle entry and a box entry seen from
// outside pass through the 31-step square root and the two 15-step divisions
// that normalize the vector; a point inside a box skips them. One word is worked
// on at a time; the input is ready again as soon as a result sits in the output
// register, and only a query that finishes while the previous result is still
// untaken waits.
// Entries are undefined until loaded; obstacle_count must be written only while
// the block is idle, which the block itself does not enforce, and a count above
// MAX_OBSTACLES is taken as MAX_OBSTACLES.
module obstacle_signed_distance_query import osdq_pkg::*; #(
	parameter int MAX_OBSTACLES = 8,
	parameter int COORD_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	osdq_req_if.sink   req,
	osdq_cfg_if.sink   cfg,
	osdq_rsp_if.source rsp
);

	// Widths of the box path: offset, products, rotated point, face gaps.
	localparam int RW = COORD_BITS + 1;
	localparam int PW = RW + 17;
	localparam int LW = RW + 3;
	localparam int QW = LW + 1;
	localparam int DW = 34;
	localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CW = $clog2(MAX_OBSTACLES + 1);
	localparam int EW = 1 + 2 * COORD_BITS + 3 * SIZE_W + 2 * ANG_W;

	typedef enum logic [4:0] {
		S_IDLE, S_RD, S_DIFF, S_CCLAMP,
		S_B1, S_B2, S_B3, S_B4, S_BFACE,
		S_SQX, S_SQY, S_SQS, S_SQW,
		S_DXS, S_DXW, S_DYS, S_DYW, S_NLOC,
		S_R1, S_R2, S_R3, S_R4, S_CMP, S_FIN
	} state_t;

	state_t state_q;

	// Configuration.
	logic [CNT_W-1:0] count_q;

	// Query context.
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [CW-1:0]                idx_q, n_q, n_eff;
	logic signed [RW-1:0]         rx_q, ry_q;
	logic signed [PW-1:0]         acc_q;
	logic signed [LW-1:0]         lx_q, ly_q;
	logic [MAG_W-1:0]             magx_q, magy_q;
	logic                         sgnx_q, sgny_q;
	logic [SQ_W-1:0]              sq_q;
	logic [LEN_W-1:0]             len_q;
	logic [QUO_W-1:0]             qnx_q;
	logic signed [NORM_W-1:0]     lnx_q, lny_q, nx_q, ny_q;
	logic signed [DW-1:0]         d_q, best_q;
	logic signed [NORM_W-1:0]     bnx_q, bny_q;
	logic                         have_q;

	// Result register.
	logic                     out_valid_q;
	logic signed [DIST_W-1:0] dist_q;
	logic signed [NORM_W-1:0] onx_q, ony_q;
	logic                     ohave_q;

	// Table.
	logic          tbl_we, tbl_re;
	logic [AW-1:0] tbl_waddr;
	logic [EW-1:0] tbl_wdata, tbl_rdata;

	logic                         e_kind;
	logic signed [COORD_BITS-1:0] e_cx, e_cy;
	logic [SIZE_W-1:0]            e_rad, e_hx, e_hy;
	logic signed [ANG_W-1:0]      e_cos, e_sin;

	// Shared rotation multiplier.
	logic signed [RW-1:0]    mul_a;
	logic signed [ANG_W-1:0] mul_b;
	logic signed [PW-1:0]    mul_p;

	// Squaring multiplier.
	logic [MAG_W-1:0] sq_op;
	logic [SQ_W-1:0]  sq_p;

	// Length units.
	logic             sqrt_start, sqrt_done;
	logic [LEN_W-1:0] sqrt_root;
	logic             div_start, div_done;
	logic [MAG_W-1:0] div_mag;
	logic [QUO_W-1:0] div_quot;

	// Face gaps of the box.
	logic [LW-1:0]        absx, absy;
	logic signed [QW-1:0] qx, qy;

	logic req_acc;

	function automatic logic signed [PW-1:0] rnd14(input logic signed [PW-1:0] v);
		logic [PW-1:0] m;
		logic [PW-1:0] r;
		m = v[PW-1] ? PW'(-v) : PW'(v);
		r = (m + PW'(8192)) >> 14;
		return v[PW-1] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [PW-1:0] v);
		if (longint'(v) > longint'(NORM_ONE)) begin
			return NORM_ONE;
		end else if (longint'(v) < -longint'(NORM_ONE)) begin
			return -NORM_ONE;
		end
		return NORM_W'(v);
	endfunction

	function automatic logic [MAG_W-1:0] clamp_mag(input longint v);
		longint a;
		a = (v < 0) ? -v : v;
		if (a > COMP_LIM) begin
			a = COMP_LIM;
		end
		return MAG_W'(a);
	endfunction

	assign req_acc   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		if (int'(count_q) > MAX_OBSTACLES) begin
			n_eff = CW'(MAX_OBSTACLES);
		end else begin
			n_eff = CW'(count_q);
		end
	end

	// Loads are written only while idle and reads happen only during a query,
	// so a read and a write never touch the same entry in overlapping cycles.
	assign tbl_we    = req_acc && req.func == FUNC_LOAD && int'(req.slot) < MAX_OBSTACLES;
	assign tbl_waddr = AW'(req.slot);
	assign tbl_wdata = {req.kind, req.coord_x, req.coord_y, req.radius, req.half_x,
		req.half_y, req.cos_angle, req.sin_angle};
	assign tbl_re    = (state_q == S_RD);
	assign {e_kind, e_cx, e_cy, e_rad, e_hx, e_hy, e_cos, e_sin} = tbl_rdata;

	osdq_table #(
		.DEPTH(MAX_OBSTACLES),
		.WIDTH(EW)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re   (tbl_re),
		.raddr(idx_q[AW-1:0]),
		.rdata(tbl_rdata)
	);

	// Operand selection for the rotation multiplier. Into the box frame:
	// lx = c*rx + s*ry, ly = c*ry - s*rx. Back out: nx = c*lnx - s*lny,
	// ny = s*lnx + c*lny.
	always_comb begin
		mul_a = rx_q;
		mul_b = e_cos;
		case (state_q)
			S_B1: begin
				mul_a = rx_q;
				mul_b = e_cos;
			end
			S_B2: begin
				mul_a = ry_q;
				mul_b = e_sin;
			end
			S_B3: begin
				mul_a = ry_q;
				mul_b = e_cos;
			end
			S_B4: begin
				mul_a = rx_q;
				mul_b = e_sin;
			end
			S_R1: begin
				mul_a = RW'(lnx_q);
				mul_b = e_cos;
			end
			S_R2: begin
				mul_a = RW'(lny_q);
				mul_b = e_sin;
			end
			S_R3: begin
				mul_a = RW'(lnx_q);
				mul_b = e_sin;
			end
			S_R4: begin
				mul_a = RW'(lny_q);
				mul_b = e_cos;
			end
			default: begin
				mul_a = rx_q;
				mul_b = e_cos;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign sq_op = (state_q == S_SQX) ? magx_q : magy_q;
	assign sq_p  = sq_op * sq_op;

	assign absx = lx_q[LW-1] ? LW'(-lx_q) : LW'(lx_q);
	assign absy = ly_q[LW-1] ? LW'(-ly_q) : LW'(ly_q);
	assign qx   = $signed({1'b0, absx}) - $signed(QW'(e_hx));
	assign qy   = $signed({1'b0, absy}) - $signed(QW'(e_hy));

	assign sqrt_start = (state_q == S_SQS);
	assign div_start  = (state_q == S_DXS) || (state_q == S_DYS);
	assign div_mag    = (state_q == S_DXS) ? magx_q : magy_q;

	osdq_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(sq_q),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	osdq_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.mag   (div_mag),
		.den   (len_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			count_q <= cfg.data;
		end
	end

	// Sequencer: one entry at a time, read, offset, length, normal, compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			n_q         <= '0;
			have_q      <= 1'b0;
		end else begin
			// In the final state the output register is handled below.
			if (rsp.valid && rsp.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc && req.func == FUNC_QUERY) begin
						px_q   <= req.coord_x;
						py_q   <= req.coord_y;
						idx_q  <= '0;
						n_q    <= n_eff;
						have_q <= 1'b0;
						best_q <= '0;
						bnx_q  <= '0;
						bny_q  <= NORM_ONE;
						state_q <= (n_eff == '0) ? S_FIN : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					rx_q <= RW'(px_q) - RW'(e_cx);
					ry_q <= RW'(py_q) - RW'(e_cy);
					state_q <= (e_kind == KIND_BOX) ? S_B1 : S_CCLAMP;
				end
				S_CCLAMP: begin
					magx_q <= clamp_mag(longint'(rx_q));
					magy_q <= clamp_mag(longint'(ry_q));
					sgnx_q <= rx_q[RW-1];
					sgny_q <= ry_q[RW-1];
					state_q <= S_SQX;
				end
				S_B1: begin
					acc_q   <= mul_p;
					state_q <= S_B2;
				end
				S_B2: begin
					lx_q    <= LW'(rnd14(acc_q + mul_p));
					state_q <= S_B3;
				end
				S_B3: begin
					acc_q   <= mul_p;
					state_q <= S_B4;
				end
				S_B4: begin
					ly_q    <= LW'(rnd14(acc_q - mul_p));
					state_q <= S_BFACE;
				end
				S_BFACE: begin
					sgnx_q <= lx_q[LW-1];
					sgny_q <= ly_q[LW-1];
					if (qx > 0 || qy > 0) begin
						// Outside: the length of the positive face gaps.
						magx_q  <= (qx > 0) ? clamp_mag(longint'(qx)) : '0;
						magy_q  <= (qy > 0) ? clamp_mag(longint'(qy)) : '0;
						state_q <= S_SQX;
					end else if (qx > qy) begin
						// Inside, nearer to a local x face.
						d_q     <= DW'(qx);
						lnx_q   <= lx_q[LW-1] ? -NORM_ONE : NORM_ONE;
						lny_q   <= '0;
						state_q <= S_R1;
					end else begin
						// Inside, local y face; it also wins a tie.
						d_q     <= DW'(qy);
						lnx_q   <= '0;
						lny_q   <= ly_q[LW-1] ? -NORM_ONE : NORM_ONE;
						state_q <= S_R1;
					end
				end
				S_SQX: begin
					sq_q    <= sq_p;
					state_q <= S_SQY;
				end
				S_SQY: begin
					sq_q    <= sq_q + sq_p;
					state_q <= S_SQS;
				end
				S_SQS: begin
					state_q <= S_SQW;
				end
				S_SQW: begin
					if (sqrt_done) begin
						len_q <= sqrt_root;
						if (e_kind == KIND_BOX) begin
							d_q <= DW'(sqrt_root);
						end else begin
							d_q <= $signed({3'b000, sqrt_root}) - $signed(DW'(e_rad));
						end
						if (sqrt_root == '0) begin
							// Zero length: fixed normals.
							if (e_kind == KIND_BOX) begin
								lnx_q   <= sgnx_q ? -NORM_ONE : NORM_ONE;
								lny_q   <= '0;
								state_q <= S_R1;
							end else begin
								nx_q    <= '0;
								ny_q    <= NORM_ONE;
								state_q <= S_CMP;
							end
						end else begin
							state_q <= S_DXS;
						end
					end
				end
				S_DXS: begin
					state_q <= S_DXW;
				end
				S_DXW: begin
					if (div_done) begin
						qnx_q   <= div_quot;
						state_q <= S_DYS;
					end
				end
				S_DYS: begin
					state_q <= S_DYW;
				end
				S_DYW: begin
					if (div_done) begin
						state_q <= S_NLOC;
						if (e_kind == KIND_BOX) begin
							lnx_q <= sgnx_q ? -NORM_W'(qnx_q) : NORM_W'(qnx_q);
							lny_q <= sgny_q ? -NORM_W'(div_quot) : NORM_W'(div_quot);
						end else begin
							nx_q <= sgnx_q ? -NORM_W'(qnx_q) : NORM_W'(qnx_q);
							ny_q <= sgny_q ? -NORM_W'(div_quot) : NORM_W'(div_quot);
						end
					end
				end
				S_NLOC: begin
					state_q <= (e_kind == KIND_BOX) ? S_R1 : S_CMP;
				end
				S_R1: begin
					acc_q   <= mul_p;
					state_q <= S_R2;
				end
				S_R2: begin
					nx_q    <= sat_norm(rnd14(acc_q - mul_p));
					state_q <= S_R3;
				end
				S_R3: begin
					acc_q   <= mul_p;
					state_q <= S_R4;
				end
				S_R4: begin
					ny_q    <= sat_norm(rnd14(acc_q + mul_p));
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!have_q || d_q < best_q) begin
						best_q <= d_q;
						bnx_q  <= nx_q;
						bny_q  <= ny_q;
					end
					have_q <= 1'b1;
					if (CW'(idx_q + CW'(1)) == n_q) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					// Wait here only while the previous result is still untaken.
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						ohave_q     <= have_q;
						onx_q       <= bnx_q;
						ony_q       <= bny_q;
						if (!have_q) begin
							dist_q <= DIST_MAX;
						end else if (best_q > DW'(DIST_MAX)) begin
							dist_q <= DIST_MAX;
						end else if (best_q < DW'(DIST_MIN)) begin
							dist_q <= DIST_MIN;
						end else begin
							dist_q <= DIST_W'(best_q);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.distance     = dist_q;
	assign rsp.normal_x     = onx_q;
	assign rsp.normal_y     = ony_q;
	assign rsp.has_obstacle = ohave_q;

`ifndef SYNTHESIS
	// A result without obstacles carries the saturated distance and the up normal.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.has_obstacle |->
			rsp.distance == DIST_MAX && rsp.normal_x == '0 && rsp.normal_y == NORM_ONE)
		else $error("empty query result has wrong distance or normal");

	// The root unit finishes only while the sequencer waits for it.
	a_sqrt_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == S_SQW)
		else $error("square root finished outside its wait state");

	// Only entries inside the effective count are read.
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD |-> idx_q < n_q)
		else $error("table read beyond the obstacle count");

	// A quotient never exceeds one in Q1.14.
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_quot <= QUO_W'(NORM_ONE))
		else $error("normal component above one");
`endif

endmodule
